// ===== hdl/sqt_pkg.sv =====
// Shared types, token kind codes and keyword lookup for the query tokenizer.
// No dependencies.
package sqt_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_WORD, MODE_INT, MODE_DOT, MODE_FRAC, MODE_STR, MODE_ESC, MODE_OPER
   } mode_type;

   localparam logic [5:0] KIND_END     = 6'd0;
   localparam logic [5:0] KIND_UNKNOWN = 6'd1;
   localparam logic [5:0] KIND_KW0     = 6'd2;
   localparam logic [5:0] KIND_IDENT   = 6'd39;
   localparam logic [5:0] KIND_INT     = 6'd40;
   localparam logic [5:0] KIND_DEC     = 6'd41;
   localparam logic [5:0] KIND_STR     = 6'd42;
   localparam logic [5:0] KIND_EQ      = 6'd43;
   localparam logic [5:0] KIND_NE      = 6'd44;
   localparam logic [5:0] KIND_LT      = 6'd45;
   localparam logic [5:0] KIND_LE      = 6'd46;
   localparam logic [5:0] KIND_GT      = 6'd47;
   localparam logic [5:0] KIND_GE      = 6'd48;
   localparam logic [5:0] KIND_STAR    = 6'd49;
   localparam logic [5:0] KIND_LPAREN  = 6'd50;
   localparam logic [5:0] KIND_RPAREN  = 6'd51;
   localparam logic [5:0] KIND_COMMA   = 6'd52;
   localparam logic [5:0] KIND_SEMI    = 6'd53;
   localparam logic [5:0] KIND_MINUS   = 6'd54;

   // Held operator byte while waiting for a possible '='.
   localparam logic [1:0] OPER_NONE    = 2'd0;
   localparam logic [1:0] OPER_BANG    = 2'd1;
   localparam logic [1:0] OPER_LESS    = 2'd2;
   localparam logic [1:0] OPER_GREATER = 2'd3;

   // Which position a result item reports.
   localparam logic [1:0] POS_TOKEN   = 2'd0;
   localparam logic [1:0] POS_DOT     = 2'd1;
   localparam logic [1:0] POS_CURRENT = 2'd2;

   localparam int KW_COUNT = 37;
   localparam int KW_MAXLEN = 9;

   // Keywords packed first character in the top byte, zero padded.
   typedef logic [8*KW_MAXLEN-1:0] kw_text_type;

   // Result item carried from the front to the back through the queue.
   typedef struct packed {
      logic [7:0] ch;
      logic       valid;
      logic       last;
      logic [5:0] kind;
      logic       err;
      logic       use_pos;   // 1: take line/column from pos fields
      logic [1:0] pos_sel;   // token start, dot or current position
   } item_type;

   function automatic kw_text_type kw_text(input int idx);
      case (idx)
         0: kw_text = {"CREATE", 24'h0};   1: kw_text = {"DROP", 40'h0};
         2: kw_text = {"DESCRIBE", 8'h0};  3: kw_text = {"TABLE", 32'h0};
         4: kw_text = {"INSERT", 24'h0};   5: kw_text = {"INTO", 40'h0};
         6: kw_text = {"VALUES", 24'h0};   7: kw_text = {"UPDATE", 24'h0};
         8: kw_text = {"SET", 48'h0};      9: kw_text = {"DELETE", 24'h0};
         10: kw_text = {"SELECT", 24'h0};  11: kw_text = {"FROM", 40'h0};
         12: kw_text = {"WHERE", 32'h0};   13: kw_text = {"ORDER", 32'h0};
         14: kw_text = {"BY", 56'h0};      15: kw_text = {"LIMIT", 32'h0};
         16: kw_text = {"ASC", 48'h0};     17: kw_text = {"DESC", 40'h0};
         18: kw_text = {"AND", 48'h0};     19: kw_text = {"PRIMARY", 16'h0};
         20: kw_text = {"KEY", 48'h0};     21: kw_text = {"INT", 48'h0};
         22: kw_text = {"FLOAT", 32'h0};   23: kw_text = {"STRING", 24'h0};
         24: kw_text = {"BOOL", 40'h0};    25: kw_text = {"SEMANTIC", 8'h0};
         26: kw_text = {"AS", 56'h0};      27: kw_text = {"OF", 56'h0};
         28: kw_text = {"BETWEEN", 16'h0}; 29: kw_text = {"SNAPSHOT", 8'h0};
         30: kw_text = {"COMPARE", 16'h0}; 31: kw_text = {"EVOLUTION"};
         32: kw_text = {"HISTORY", 16'h0}; 33: kw_text = {"ROLLBACK", 8'h0};
         34: kw_text = {"TO", 56'h0};      35: kw_text = {"COMPACT", 16'h0};
         default: kw_text = {"SIMILAR", 16'h0};
      endcase
   endfunction

   function automatic logic [3:0] kw_len(input int idx);
      kw_text_type t;
      logic [3:0]  n;
      t = kw_text(idx);
      n = 4'd0;
      for (int i = 0; i < KW_MAXLEN; i++)
         if (t[8*(KW_MAXLEN-1-i) +: 8] != 8'h0) n = 4'(i + 1);
      return n;
   endfunction

endpackage

// ===== hdl/sqt_front.sv =====
// Front end: accepts bytes, runs the lexer state machine and writes up to three
// result items per byte into the queue. Depends on sqt_pkg.
module sqt_front import sqt_pkg::*; #(
   parameter int MAX_KEYWORD_LEN = 9,
   parameter int POS_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_char,
   input  logic                 in_end,
   input  logic                 q_room,     // queue can take three items
   output logic [1:0]           q_count,
   output item_type             q_item [3],
   output logic [POS_WIDTH-1:0] q_line [3],
   output logic [POS_WIDTH-1:0] q_col [3]
);

   localparam logic [POS_WIDTH-1:0] POS_MAX = '1;
   localparam logic [POS_WIDTH-1:0] POS_ONE = POS_WIDTH'(1);
   localparam int LW = $clog2(MAX_KEYWORD_LEN + 2);

   mode_type mode_ff, mode_in;
   logic quote_ff, quote_in;
   logic [1:0] oper_ff, oper_in;
   logic [7:0] kbuf_ff [MAX_KEYWORD_LEN];
   logic [7:0] kbuf_in [MAX_KEYWORD_LEN];
   logic [LW-1:0] wlen_ff, wlen_in;
   logic [POS_WIDTH-1:0] line_ff, line_in, col_ff, col_in;
   logic [POS_WIDTH-1:0] tline_ff, tline_in, tcol_ff, tcol_in, dcol_ff, dcol_in;

   logic fire;
   assign in_ready = q_room;
   assign fire = in_valid && q_room;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction
   function automatic logic is_wstart(input logic [7:0] c);
      return is_alpha(c) || c == "_";
   endfunction

   // Keyword match against the buffered upper-case word.
   logic [5:0] word_kind;
   always_comb begin
      kw_text_type t;
      logic hit;
      word_kind = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         t = kw_text(k);
         hit = (LW'(kw_len(k)) == wlen_ff);
         for (int i = 0; i < KW_MAXLEN; i++)
            if (i < int'(kw_len(k)) && kbuf_ff[i] != t[8*(KW_MAXLEN-1-i) +: 8]) hit = 1'b0;
         if (hit) word_kind = KIND_KW0 + 6'(k);
      end
   end

   logic [7:0] oper_char;
   always_comb begin
      case (oper_ff)
         OPER_BANG: oper_char = "!";
         OPER_LESS: oper_char = "<";
         default: oper_char = ">";
      endcase
   end

   always_comb begin
      item_type it [3];
      logic [1:0] n;
      logic start;
      logic [7:0] c, up;
      c = in_char;
      up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      mode_in = mode_ff; quote_in = quote_ff; oper_in = oper_ff;
      kbuf_in = kbuf_ff; wlen_in = wlen_ff;
      line_in = line_ff; col_in = col_ff;
      tline_in = tline_ff; tcol_in = tcol_ff; dcol_in = dcol_ff;
      for (int i = 0; i < 3; i++) it[i] = '0;
      n = 2'd0;
      start = 1'b0;
      if (in_end) begin
         case (mode_ff)
            MODE_WORD: begin
               it[0] = '{8'h0, 1'b0, 1'b1, word_kind, 1'b0, 1'b0, POS_TOKEN}; n = 2'd1;
            end
            MODE_INT: begin
               it[0] = '{8'h0, 1'b0, 1'b1, KIND_INT, 1'b0, 1'b0, POS_TOKEN}; n = 2'd1;
            end
            MODE_DOT: begin
               it[0] = '{8'h0, 1'b0, 1'b1, KIND_INT, 1'b0, 1'b0, POS_TOKEN};
               it[1] = '{".", 1'b1, 1'b1, KIND_UNKNOWN, 1'b0, 1'b1, POS_DOT};
               n = 2'd2;
            end
            MODE_FRAC: begin
               it[0] = '{8'h0, 1'b0, 1'b1, KIND_DEC, 1'b0, 1'b0, POS_TOKEN}; n = 2'd1;
            end
            MODE_STR, MODE_ESC: begin
               it[0] = '{8'h0, 1'b0, 1'b1, KIND_STR, 1'b1, 1'b0, POS_TOKEN}; n = 2'd1;
            end
            MODE_OPER: begin
               it[0] = '{oper_char, 1'b1, 1'b1, (oper_ff == OPER_BANG) ? KIND_UNKNOWN :
                         (oper_ff == OPER_LESS) ? KIND_LT : KIND_GT, 1'b0, 1'b0, POS_TOKEN};
               n = 2'd1;
            end
            default: ;
         endcase
         it[n] = '{8'h0, 1'b0, 1'b1, KIND_END, 1'b0, 1'b1, POS_CURRENT};
         n = n + 2'd1;
         mode_in = MODE_IDLE; quote_in = 1'b0; oper_in = OPER_NONE;
         for (int i = 0; i < MAX_KEYWORD_LEN; i++) kbuf_in[i] = 8'h0;
         wlen_in = '0;
         line_in = POS_ONE; col_in = POS_ONE;
         tline_in = POS_ONE; tcol_in = POS_ONE; dcol_in = POS_ONE;
      end else begin
         case (mode_ff)
            MODE_WORD: begin
               if (is_wstart(c) || is_digit(c)) begin
                  if (wlen_ff < LW'(MAX_KEYWORD_LEN))
                     kbuf_in[wlen_ff[$clog2(MAX_KEYWORD_LEN)-1:0]] = up;
                  if (wlen_ff <= LW'(MAX_KEYWORD_LEN)) wlen_in = wlen_ff + 1'b1;
                  it[0] = '{c, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0, POS_TOKEN}; n = 2'd1;
               end else begin
                  it[0] = '{8'h0, 1'b0, 1'b1, word_kind, 1'b0, 1'b0, POS_TOKEN}; n = 2'd1;
                  start = 1'b1;
               end
            end
            MODE_INT: begin
               if (is_digit(c)) begin
                  it[0] = '{c, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0, POS_TOKEN}; n = 2'd1;
               end else if (c == ".") begin
                  mode_in = MODE_DOT; dcol_in = col_ff;
               end else begin
                  it[0] = '{8'h0, 1'b0, 1'b1, KIND_INT, 1'b0, 1'b0, POS_TOKEN}; n = 2'd1;
                  start = 1'b1;
               end
            end
            MODE_DOT: begin
               if (is_digit(c)) begin
                  it[0] = '{".", 1'b1, 1'b0, 6'd0, 1'b0, 1'b0, POS_TOKEN};
                  it[1] = '{c, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0, POS_TOKEN};
                  n = 2'd2; mode_in = MODE_FRAC;
               end else begin
                  it[0] = '{8'h0, 1'b0, 1'b1, KIND_INT, 1'b0, 1'b0, POS_TOKEN};
                  it[1] = '{".", 1'b1, 1'b1, KIND_UNKNOWN, 1'b0, 1'b1, POS_DOT};
                  n = 2'd2; start = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (is_digit(c)) begin
                  it[0] = '{c, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0, POS_TOKEN}; n = 2'd1;
               end else begin
                  it[0] = '{8'h0, 1'b0, 1'b1, KIND_DEC, 1'b0, 1'b0, POS_TOKEN}; n = 2'd1;
                  start = 1'b1;
               end
            end
            MODE_STR: begin
               if (c == (quote_ff ? 8'h27 : 8'h22)) begin
                  it[0] = '{8'h0, 1'b0, 1'b1, KIND_STR, 1'b0, 1'b0, POS_TOKEN}; n = 2'd1;
                  mode_in = MODE_IDLE;
               end else if (c == 8'h5c) begin
                  mode_in = MODE_ESC;
               end else begin
                  it[0] = '{c, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0, POS_TOKEN}; n = 2'd1;
               end
            end
            MODE_ESC: begin
               it[0] = '{(c == "n") ? 8'd10 : (c == "t") ? 8'd9 : c,
                         1'b1, 1'b0, 6'd0, 1'b0, 1'b0, POS_TOKEN};
               n = 2'd1; mode_in = MODE_STR;
            end
            MODE_OPER: begin
               if (c == "=") begin
                  it[0] = '{oper_char, 1'b1, 1'b0, 6'd0, 1'b0, 1'b0, POS_TOKEN};
                  it[1] = '{"=", 1'b1, 1'b1, (oper_ff == OPER_BANG) ? KIND_NE :
                            (oper_ff == OPER_LESS) ? KIND_LE : KIND_GE, 1'b0, 1'b0, POS_TOKEN};
                  n = 2'd2; mode_in = MODE_IDLE; oper_in = OPER_NONE;
               end else begin
                  it[0] = '{oper_char, 1'b1, 1'b1, (oper_ff == OPER_BANG) ? KIND_UNKNOWN :
                            (oper_ff == OPER_LESS) ? KIND_LT : KIND_GT, 1'b0, 1'b0, POS_TOKEN};
                  n = 2'd1; start = 1'b1;
               end
            end
            default: start = 1'b1;
         endcase
         if (start) begin
            mode_in = MODE_IDLE; oper_in = OPER_NONE;
            if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
               tline_in = line_ff; tcol_in = col_ff;
               // The new token may be emitted in this same step, so it uses the
               // current position directly.
               if (is_wstart(c)) begin
                  mode_in = MODE_WORD;
                  for (int i = 0; i < MAX_KEYWORD_LEN; i++) kbuf_in[i] = kbuf_ff[i];
                  kbuf_in[0] = up;
                  wlen_in = LW'(1);
                  it[n] = '{c, 1'b1, 1'b0, 6'd0, 1'b0, 1'b1, POS_CURRENT}; n = n + 2'd1;
               end else if (is_digit(c)) begin
                  mode_in = MODE_INT;
                  it[n] = '{c, 1'b1, 1'b0, 6'd0, 1'b0, 1'b1, POS_CURRENT}; n = n + 2'd1;
               end else if (c == 8'h22 || c == 8'h27) begin
                  mode_in = MODE_STR; quote_in = (c == 8'h27);
               end else if (c == "=") begin
                  it[n] = '{c, 1'b1, 1'b1, KIND_EQ, 1'b0, 1'b1, POS_CURRENT}; n = n + 2'd1;
               end else if (c == "!" || c == "<" || c == ">") begin
                  mode_in = MODE_OPER;
                  oper_in = (c == "!") ? OPER_BANG : (c == "<") ? OPER_LESS : OPER_GREATER;
               end else begin
                  logic [5:0] sk;
                  case (c)
                     "*": sk = KIND_STAR;
                     "(": sk = KIND_LPAREN;
                     ")": sk = KIND_RPAREN;
                     ",": sk = KIND_COMMA;
                     ";": sk = KIND_SEMI;
                     "-": sk = KIND_MINUS;
                     default: sk = KIND_UNKNOWN;
                  endcase
                  it[n] = '{c, 1'b1, 1'b1, sk, 1'b0, 1'b1, POS_CURRENT}; n = n + 2'd1;
               end
            end
         end
         if (c == 8'd10) begin
            if (line_ff != POS_MAX) line_in = line_ff + 1'b1;
            col_in = POS_ONE;
         end else if (col_ff != POS_MAX) begin
            col_in = col_ff + 1'b1;
         end
      end
      q_count = fire ? n : 2'd0;
      for (int i = 0; i < 3; i++) begin
         q_item[i] = it[i];
         q_item[i].use_pos = 1'b1;
         q_item[i].pos_sel = POS_TOKEN;
         q_line[i] = tline_ff;
         q_col[i] = tcol_ff;
         if (it[i].use_pos) begin
            case (it[i].pos_sel)
               POS_DOT: begin q_line[i] = line_ff; q_col[i] = dcol_ff; end
               default: begin q_line[i] = line_ff; q_col[i] = col_ff; end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE; quote_ff <= 1'b0; oper_ff <= OPER_NONE;
         for (int i = 0; i < MAX_KEYWORD_LEN; i++) kbuf_ff[i] <= 8'h0;
         wlen_ff <= '0;
         line_ff <= POS_ONE; col_ff <= POS_ONE;
         tline_ff <= POS_ONE; tcol_ff <= POS_ONE; dcol_ff <= POS_ONE;
      end else if (fire) begin
         mode_ff <= mode_in; quote_ff <= quote_in; oper_ff <= oper_in;
         kbuf_ff <= kbuf_in; wlen_ff <= wlen_in;
         line_ff <= line_in; col_ff <= col_in;
         tline_ff <= tline_in; tcol_ff <= tcol_in; dcol_ff <= dcol_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fire && in_end |=> mode_ff == MODE_IDLE && line_ff == POS_ONE)
      else $error("end of input did not restore the scanner");
   assert property (@(posedge clock) disable iff (reset)
      fire && in_end |-> q_count != 2'd0)
      else $error("end of input produced no end token");
   assert property (@(posedge clock) disable iff (reset)
      wlen_ff <= LW'(MAX_KEYWORD_LEN + 1))
      else $error("word length ran past its limit");

endmodule

// ===== hdl/sqt_queue.sv =====
// Result queue between the lexer front end and the output port. Takes up to
// three items per cycle and hands out one. Depends on sqt_pkg.
module sqt_queue import sqt_pkg::*; #(
   parameter int POS_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           wr_count,
   input  item_type             wr_item [3],
   input  logic [POS_WIDTH-1:0] wr_line [3],
   input  logic [POS_WIDTH-1:0] wr_col [3],
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output item_type             out_item,
   output logic [POS_WIDTH-1:0] out_line,
   output logic [POS_WIDTH-1:0] out_col
);

   localparam int DEPTH = 8;
   localparam int AW = 3;

   item_type             item_ff [DEPTH];
   logic [POS_WIDTH-1:0] line_ff [DEPTH];
   logic [POS_WIDTH-1:0] col_ff [DEPTH];
   logic [AW-1:0] rd_ff, wr_ff;
   logic [AW:0]   cnt_ff, cnt_in;
   logic pop;

   assign out_valid = cnt_ff != '0;
   assign pop = out_valid && out_ready;
   // Room for a worst-case byte whatever the reader does this cycle.
   assign room = cnt_ff <= (AW+1)'(DEPTH - 3);
   assign out_item = item_ff[rd_ff];
   assign out_line = line_ff[rd_ff];
   assign out_col = col_ff[rd_ff];
   assign cnt_in = cnt_ff + (AW+1)'(wr_count) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++)
         if (2'(i) < wr_count) begin
            item_ff[wr_ff + AW'(i)] <= wr_item[i];
            line_ff[wr_ff + AW'(i)] <= wr_line[i];
            col_ff[wr_ff + AW'(i)] <= wr_col[i];
         end
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_ff + AW'(wr_count);
         rd_ff <= rd_ff + AW'(pop);
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= (AW+1)'(DEPTH))
      else $error("result queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready && wr_count == 2'd0 |=> out_valid && $stable(out_item))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset) wr_count != 2'd0 |-> room)
      else $error("result queue written without room");

endmodule

// ===== hdl/sql_query_tokenizer_top.sv =====
// Channel  Direction  Payload
// req_     in         tdata: in_char; tlast: end_of_input
// rsp_     out        tdata: value_char, start_line, start_column; tlast: last_of_token;
//                     tuser: char_valid, token_kind, unterminated_error
// One byte is accepted per cycle while req_tready is high; a byte that yields
// up to three result items enters the eight-entry result queue at its accepting
// edge, and its first item is offered once the queued items ahead of it are taken.
// The output drains one item per cycle while rsp_tready is high.
// req_tready drops when fewer than three queue entries are free.
// Synchronous active-high reset returns the scanner to line 1, column 1.
// Depends on sqt_pkg, sqt_front and sqt_queue.
module sql_query_tokenizer_top import sqt_pkg::*; #(
   parameter int MAX_KEYWORD_LEN = 9,
   parameter int POS_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // in_char
   input  logic                                 req_tlast,   // end_of_input
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // value_char, start_line, start_column, zero fill
   output logic [((2*POS_WIDTH+15)/8)*8-1:0]    rsp_tdata,
   output logic                                 rsp_tlast,   // last_of_token
   // char_valid, token_kind, unterminated_error
   output logic [7:0]                           rsp_tuser
);

   localparam int TDATA_W = ((2*POS_WIDTH+15)/8)*8;

   logic [1:0] q_count;
   item_type q_item [3];
   logic [POS_WIDTH-1:0] q_line [3], q_col [3];
   logic room;
   item_type o_item;
   logic [POS_WIDTH-1:0] o_line, o_col;

   sqt_front #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN), .POS_WIDTH(POS_WIDTH)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_char(req_tdata), .in_end(req_tlast), .q_room(room), .q_count(q_count),
      .q_item(q_item), .q_line(q_line), .q_col(q_col)
   );

   sqt_queue #(.POS_WIDTH(POS_WIDTH)) u_queue (
      .clock(clock), .reset(reset), .wr_count(q_count), .wr_item(q_item),
      .wr_line(q_line), .wr_col(q_col), .room(room), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_item(o_item), .out_line(o_line), .out_col(o_col)
   );

   assign rsp_tdata = TDATA_W'({o_col, o_line, o_item.ch});
   assign rsp_tlast = o_item.last;
   assign rsp_tuser = {o_item.err, o_item.kind, o_item.valid};

endmodule

// ===== tb/tb_token_checker.sv =====
// Predicts the result stream of the query tokenizer from the accepted input bytes and
// compares every accepted result transaction. Depends on sqt_pkg for the token kind codes.
module tb_token_checker import sqt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic [7:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count,
   output int          token_count
);

   typedef struct packed {
      logic [7:0]  ch;
      logic        valid;
      logic        last;
      logic [5:0]  kind;
      logic [15:0] line;
      logic [15:0] col;
      logic        err;
   } token_item_t;

   localparam logic [15:0] POS_TOP = 16'hFFFF;

   token_item_t expected_tokens[$];
   mode_type    mode;
   logic        single_quote;
   logic [1:0]  held_op;
   logic [7:0]  word_buf[9];
   int          word_len;
   logic [15:0] cur_line, cur_col, tok_line, tok_col, dot_col;

   function automatic bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic bit is_let(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
   endfunction

   task automatic emit(logic [7:0] c, logic v, logic l, logic [5:0] k,
                       logic [15:0] ln, logic [15:0] cl, logic e);
      token_item_t t;
      t.ch = v ? c : 8'd0;
      t.valid = v;
      t.last = l;
      t.kind = l ? k : KIND_END;
      t.line = ln;
      t.col = cl;
      t.err = e;
      expected_tokens = {expected_tokens, t};
   endtask

   task automatic emit_tok(logic [7:0] c, logic v, logic l, logic [5:0] k);
      emit(c, v, l, k, tok_line, tok_col, 1'b0);
   endtask

   function automatic logic [5:0] classify_word();
      string w;
      string names[37] = '{"CREATE", "DROP", "DESCRIBE", "TABLE", "INSERT", "INTO",
         "VALUES", "UPDATE", "SET", "DELETE", "SELECT", "FROM", "WHERE", "ORDER", "BY",
         "LIMIT", "ASC", "DESC", "AND", "PRIMARY", "KEY", "INT", "FLOAT", "STRING",
         "BOOL", "SEMANTIC", "AS", "OF", "BETWEEN", "SNAPSHOT", "COMPARE", "EVOLUTION",
         "HISTORY", "ROLLBACK", "TO", "COMPACT", "SIMILAR"};
      if (word_len > 9) return KIND_IDENT;
      w = "";
      for (int i = 0; i < word_len; i++) w = {w, string'(word_buf[i])};
      for (int i = 0; i < 37; i++)
         if (names[i] == w) return KIND_KW0 + 6'(i);
      return KIND_IDENT;
   endfunction

   task automatic add_letter(logic [7:0] c);
      if (word_len < 9) word_buf[word_len] = (c >= "a" && c <= "z") ? c - 8'd32 : c;
      if (word_len <= 9) word_len++;
   endtask

   function automatic logic [7:0] held_char();
      return held_op == OPER_BANG ? "!" : (held_op == OPER_LESS ? "<" : ">");
   endfunction
   function automatic logic [5:0] held_kind(bit with_eq);
      if (held_op == OPER_BANG) return with_eq ? KIND_NE : KIND_UNKNOWN;
      if (held_op == OPER_LESS) return with_eq ? KIND_LE : KIND_LT;
      return with_eq ? KIND_GE : KIND_GT;
   endfunction

   task automatic restart_scan();
      mode = MODE_IDLE;
      single_quote = 1'b0;
      held_op = OPER_NONE;
      word_len = 0;
      foreach (word_buf[i]) word_buf[i] = 8'd0;
      cur_line = 16'd1;
      cur_col = 16'd1;
      tok_line = 16'd1;
      tok_col = 16'd1;
      dot_col = 16'd1;
   endtask

   task automatic close_token(bit at_end);
      case (mode)
         MODE_WORD: emit_tok(8'd0, 1'b0, 1'b1, classify_word());
         MODE_INT: emit_tok(8'd0, 1'b0, 1'b1, KIND_INT);
         MODE_DOT: begin
            emit_tok(8'd0, 1'b0, 1'b1, KIND_INT);
            emit(".", 1'b1, 1'b1, KIND_UNKNOWN, cur_line, dot_col, 1'b0);
         end
         MODE_FRAC: emit_tok(8'd0, 1'b0, 1'b1, KIND_DEC);
         MODE_STR, MODE_ESC:
            if (at_end) emit(8'd0, 1'b0, 1'b1, KIND_STR, tok_line, tok_col, 1'b1);
         MODE_OPER: emit_tok(held_char(), 1'b1, 1'b1, held_kind(1'b0));
         default: ;
      endcase
      mode = MODE_IDLE;
      held_op = OPER_NONE;
   endtask

   task automatic step_position(logic [7:0] c);
      if (c == 8'h0A) begin
         if (cur_line < POS_TOP) cur_line++;
         cur_col = 16'd1;
      end else if (cur_col < POS_TOP) begin
         cur_col++;
      end
   endtask

   function automatic logic [5:0] symbol_code(logic [7:0] c);
      case (c)
         "*": return KIND_STAR;
         "(": return KIND_LPAREN;
         ")": return KIND_RPAREN;
         ",": return KIND_COMMA;
         ";": return KIND_SEMI;
         "-": return KIND_MINUS;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   task automatic begin_token(logic [7:0] c);
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
      tok_line = cur_line;
      tok_col = cur_col;
      if (is_let(c)) begin
         mode = MODE_WORD;
         word_len = 0;
         add_letter(c);
         emit_tok(c, 1'b1, 1'b0, KIND_END);
      end else if (is_dig(c)) begin
         mode = MODE_INT;
         emit_tok(c, 1'b1, 1'b0, KIND_END);
      end else if (c == "\"" || c == "'") begin
         mode = MODE_STR;
         single_quote = (c == "'");
      end else if (c == "=") begin
         emit_tok(c, 1'b1, 1'b1, KIND_EQ);
      end else if (c == "!" || c == "<" || c == ">") begin
         mode = MODE_OPER;
         held_op = c == "!" ? OPER_BANG : (c == "<" ? OPER_LESS : OPER_GREATER);
      end else begin
         emit_tok(c, 1'b1, 1'b1, symbol_code(c));
      end
   endtask

   task automatic scan_byte(logic [7:0] c, logic eoi);
      if (eoi) begin
         close_token(1'b1);
         emit(8'd0, 1'b0, 1'b1, KIND_END, cur_line, cur_col, 1'b0);
         restart_scan();
         return;
      end
      case (mode)
         MODE_WORD:
            if (is_let(c) || is_dig(c)) begin
               add_letter(c);
               emit_tok(c, 1'b1, 1'b0, KIND_END);
               step_position(c);
               return;
            end else close_token(1'b0);
         MODE_INT:
            if (is_dig(c)) begin
               emit_tok(c, 1'b1, 1'b0, KIND_END);
               step_position(c);
               return;
            end else if (c == ".") begin
               mode = MODE_DOT;
               dot_col = cur_col;
               step_position(c);
               return;
            end else close_token(1'b0);
         MODE_DOT:
            if (is_dig(c)) begin
               emit_tok(".", 1'b1, 1'b0, KIND_END);
               emit_tok(c, 1'b1, 1'b0, KIND_END);
               mode = MODE_FRAC;
               step_position(c);
               return;
            end else close_token(1'b0);
         MODE_FRAC:
            if (is_dig(c)) begin
               emit_tok(c, 1'b1, 1'b0, KIND_END);
               step_position(c);
               return;
            end else close_token(1'b0);
         MODE_STR: begin
            if (c == (single_quote ? 8'h27 : 8'h22)) begin
               emit_tok(8'd0, 1'b0, 1'b1, KIND_STR);
               mode = MODE_IDLE;
            end else if (c == 8'h5C) begin
               mode = MODE_ESC;
            end else begin
               emit_tok(c, 1'b1, 1'b0, KIND_END);
            end
            step_position(c);
            return;
         end
         MODE_ESC: begin
            emit_tok(c == "n" ? 8'd10 : (c == "t" ? 8'd9 : c), 1'b1, 1'b0, KIND_END);
            mode = MODE_STR;
            step_position(c);
            return;
         end
         MODE_OPER:
            if (c == "=") begin
               emit_tok(held_char(), 1'b1, 1'b0, KIND_END);
               emit_tok("=", 1'b1, 1'b1, held_kind(1'b1));
               mode = MODE_IDLE;
               held_op = OPER_NONE;
               step_position(c);
               return;
            end else close_token(1'b0);
         default: mode = MODE_IDLE;
      endcase
      begin_token(c);
      step_position(c);
   endtask

   token_item_t got, want;

   assign pending_count = expected_tokens.size();

   always @(posedge clock) begin
      if (reset) begin
         restart_scan();
         expected_tokens.delete();
         fail_count <= 0;
         token_count <= 0;
      end else begin
         // Results are checked before the byte of this edge is scanned: a byte never
         // produces a result in its own acceptance cycle.
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tuser[0], rsp_tlast, rsp_tuser[6:1],
                   rsp_tdata[23:8], rsp_tdata[39:24], rsp_tuser[7]};
            if (got.last) token_count <= token_count + 1;
            if (expected_tokens.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result transaction: %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_tokens.pop_front();
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("mismatch: expected ch=%h v=%b l=%b k=%0d ln=%0d col=%0d e=%b,",
                        want.ch, want.valid, want.last, want.kind, want.line, want.col,
                        want.err);
                     $display("          got ch=%h v=%b l=%b k=%0d ln=%0d col=%0d e=%b",
                        got.ch, got.valid, got.last, got.kind, got.line, got.col,
                        got.err);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the query tokenizer regression: directed SQL text, then
// random token streams with idling and back pressure. Depends on sqt_pkg and tb_token_checker.
module tb_top;

   logic        clock, reset;
   logic        req_tvalid, req_tready, req_tlast;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid, rsp_tready, rsp_tlast;
   logic [39:0] rsp_tdata;
   logic [7:0]  rsp_tuser;
   int          fail_count, pending_count, token_count;
   int          bytes_sent;
   bit          calm_phase;
   bit          long_hold;

   sql_query_tokenizer_top dut (.*);

   tb_token_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("sql_query_tokenizer_top regression: fail");
      $finish;
   end

   // Receiver: random stall bursts, a long hold-off when asked, none at the end.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (60) @(negedge clock);
            long_hold = 1'b0;
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Leaves req_tvalid high after the transaction; callers drop it before waiting.
   task automatic send_byte(logic [7:0] c, logic eoi);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   function automatic string random_word();
      string pool[12] = '{"select", "FROM", "Where", "evolution", "EVOLUTIONS",
         "similar", "x_1", "_tmp", "Create", "compact", "abcdefghijk", "to"};
      return pool[$urandom_range(0, 11)];
   endfunction

   // One well-formed token with random content, or a noise byte now and then.
   task automatic send_random_token();
      case ($urandom_range(0, 7))
         0: send_text(random_word());
         1: begin
            send_byte(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
            if ($urandom_range(0, 1)) send_byte(".", 1'b0);
            send_byte(8'("0") + 8'($urandom_range(0, 9)), 1'b0);
         end
         2: begin
            send_byte($urandom_range(0, 1) ? "'" : "\"", 1'b0);
            send_text($urandom_range(0, 1) ? "a\\nb" : "q\\t\\'");
            send_byte($urandom_range(0, 1) ? "'" : "\"", 1'b0);
         end
         3: send_text($urandom_range(0, 1) ? "<=" : "!");
         4: send_byte(8'($urandom_range(0, 255)), 1'b0);
         5: send_text($urandom_range(0, 1) ? ">=" : "=");
         6: send_byte($urandom_range(0, 1) ? 8'h0A : " ", 1'b0);
         default: send_text("(*),;-");
      endcase
      if ($urandom_range(0, 2) == 0) send_byte(" ", 1'b0);
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tlast = 1'b0;
      reset = 1'b1;
      calm_phase = 1'b0;
      long_hold = 1'b0;
      bytes_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: keywords, numbers, held dot, operators, strings, high bytes, ends.
      send_text("SELECT x FROM t\nWHERE a>=1.5;");
      send_text("7.x !=!a<b\t\"s\\q\"'");
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_text("'un\\");
      send_byte(8'hA5, 1'b1);
      send_text("3.");
      send_byte(8'h00, 1'b1);
      send_byte(8'h5A, 1'b1);
      req_tvalid <= 1'b0;

      // Sender waits for every expected result before going on.
      while (pending_count != 0) @(negedge clock);

      long_hold = 1'b1;
      for (int i = 0; i < 15; i++) send_random_token();
      for (int i = 0; i < 30; i++) begin
         if (i == 22) calm_phase = 1'b1;
         send_random_token();
         if ($urandom_range(0, 25) == 0) send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      send_byte(8'd0, 1'b1);
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("Sent %0d bytes; checked %0d closed tokens across keywords, numbers,",
               bytes_sent, token_count);
      $display("strings, operators, unknown bytes and end-of-input flushes.");
      if (fail_count == 0 && pending_count == 0)
         $display("sql_query_tokenizer_top regression: pass");
      else
         $display("sql_query_tokenizer_top regression: fail");
      $finish;
   end

endmodule
